FILE: design/pskc_pkg.sv
// Shared types and constants for the peak soft-knee compressor.
// Holds the word structs, action and state codes, and the register reset values.
// No dependencies.
package pskc_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int REG_WIDTH    = 21;
    localparam int CFG_IDX_W    = 1;

    localparam logic [REG_WIDTH-1:0] KNEE_RESET = REG_WIDTH'(525533);
    localparam logic [REG_WIDTH-1:0] TRIG_RESET = REG_WIDTH'(1038090);

    localparam logic [CFG_IDX_W-1:0] CFG_KNEE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG = 1'b1;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_MEASURE = 2'd1,
        ACT_APPLY   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_P,
        ST_CHECK,
        ST_MUL,
        ST_DIV_Q,
        ST_SCALE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        action_t                  action;
        logic [SAMPLE_WIDTH-1:0]  sample_in;
    } in_word_t;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0]  sample_out;
        logic                     was_compressed;
    } out_word_t;

endpackage

FILE: design/pskc_divider.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Used twice per compressed sample by the compressor top level.
// No package dependencies.
module pskc_divider #(
    parameter int DIVW = 44,
    parameter int DW   = 23
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DIVW-1:0] dividend,
    input  logic [DW-1:0]   divisor,
    output logic            done,
    output logic [DIVW-1:0] quotient
);

    localparam int CNTW = $clog2(DIVW + 1);

    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   rem_next;
    logic [DW-1:0]   div_reg;
    logic [DIVW-1:0] dq_reg;
    logic [DIVW-1:0] dq_next;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DW:0]     shifted;
    logic [DW:0]     diff;
    logic            ge;

    always_comb
    begin
        shifted  = {rem_reg, dq_reg[DIVW-1]};
        diff     = shifted - {1'b0, div_reg};
        ge       = !diff[DW];
        rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
        dq_next  = {dq_reg[DIVW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(DIVW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            div_reg <= divisor;
            dq_reg  <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

FILE: design/peak_soft_knee_compressor_top.sv
// Peak limiter with a linear soft knee over signed fixed-point sample words.
// Depends on pskc_pkg and pskc_divider.
//
// Clear and measure words are taken from idle and give no result. An apply word
// whose stored peak is at or below the trigger level goes straight to the finish
// state, and its result is loaded into the output register once that is free.
// Otherwise the block divides the peak by the trigger level and, when the magnitude
// is at or above the knee and the scaled peak above it, multiplies the knee terms
// bit-serially over an MW-bit factor and divides again, where MW = max(FRAC_BITS, 21) + 1
// and the dividend is DIVW = 23 + MW bits wide. The single radix-2 divider is used for
// both divisions at one quotient bit per cycle. One word is processed at a time; a
// finished result waits in the output register while the next word is taken.
module peak_soft_knee_compressor_top
    import pskc_pkg::*;
#(
    parameter int FRAC_BITS = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [REG_WIDTH-1:0]  cfg_data
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int MAGW = SW - 1;
    localparam int KW   = REG_WIDTH;
    localparam int MW   = ((FRAC_BITS > KW) ? FRAC_BITS : KW) + 1;
    localparam int DIVW = MAGW + MW;
    localparam int DW   = (KW > MAGW) ? KW : MAGW;
    localparam int CW   = DW + 1;
    localparam int RW   = DIVW + 2;
    localparam int MCW  = $clog2(MW + 1);

    localparam logic [MW:0]          ONE_OC = (MW+1)'(1) << FRAC_BITS;
    localparam logic signed [RW-1:0] ONE_R  = RW'(1) << FRAC_BITS;
    localparam logic signed [RW-1:0] SMAX_R = (RW'(1) << (SW - 1)) - RW'(1);
    localparam logic signed [RW-1:0] SMIN_R = -SMAX_R - RW'(1);

    state_t                 state_reg;
    state_t                 state_next;

    logic [KW-1:0]          knee_reg;
    logic [KW-1:0]          trig_reg;
    logic [MAGW-1:0]        peak_reg;
    logic [MAGW-1:0]        peak_next;

    logic                   neg_reg;
    logic                   neg_next;
    logic [MAGW-1:0]        mag_reg;
    logic [MAGW-1:0]        mag_next;
    logic [SW-1:0]          x_reg;
    logic [SW-1:0]          x_next;
    logic [MAGW-1:0]        p_reg;
    logic [MAGW-1:0]        p_next;
    logic [MAGW-1:0]        den_reg;
    logic [MAGW-1:0]        den_next;
    logic [DIVW-1:0]        mul_a_reg;
    logic [DIVW-1:0]        mul_a_next;
    logic [MW-1:0]          mul_b_reg;
    logic [MW-1:0]          mul_b_next;
    logic [MCW-1:0]         mcnt_reg;
    logic [MCW-1:0]         mcnt_next;
    logic [DIVW-1:0]        acc_reg;
    logic [DIVW-1:0]        acc_next;
    logic                   qneg_reg;
    logic                   qneg_next;
    logic signed [RW-1:0]   qv_reg;
    logic signed [RW-1:0]   qv_next;
    logic [SW-1:0]          y_reg;
    logic [SW-1:0]          y_next;
    logic                   flag_reg;
    logic                   flag_next;

    logic                   out_valid_reg;
    out_word_t              out_data_reg;

    logic                   in_acc;
    logic                   out_load;
    logic                   div_start;
    logic                   div_done;
    logic [DIVW-1:0]        div_quo;
    logic [DIVW-1:0]        div_dividend;
    logic [DW-1:0]          div_divisor;

    logic [SW-1:0]          negx;
    logic [MAGW-1:0]        mag_in;
    logic                   peak_gt_trig;
    logic [KW-1:0]          trig_div;
    logic [CW-1:0]          c_ext;
    logic [CW-1:0]          p_ext;
    logic [CW-1:0]          m_ext;
    logic [CW-1:0]          den_ext;
    logic                   knee_go;
    logic                   pm_neg;
    logic [MAGW-1:0]        pm_abs;
    logic [MW:0]            oc;
    logic [MW:0]            oc_negated;
    logic [MW-1:0]          oc_abs;
    logic signed [RW-1:0]   y_full;

    always_comb
    begin
        negx         = -in_data.sample_in;
        mag_in       = in_data.sample_in[SW-1]
                       ? (negx[SW-1] ? {MAGW{1'b1}} : negx[MAGW-1:0])
                       : in_data.sample_in[MAGW-1:0];
        peak_gt_trig = CW'(peak_reg) > CW'(trig_reg);
        trig_div     = (trig_reg == '0) ? KW'(1) : trig_reg;

        c_ext   = CW'(knee_reg);
        p_ext   = CW'(p_reg);
        m_ext   = CW'(mag_reg);
        den_ext = p_ext - c_ext;
        knee_go = (m_ext >= c_ext) && (p_ext > c_ext);
        pm_neg  = mag_reg > p_reg;
        pm_abs  = pm_neg ? (mag_reg - p_reg) : (p_reg - mag_reg);

        oc         = ONE_OC - (MW+1)'(knee_reg);
        oc_negated = -oc;
        oc_abs     = oc[MW] ? oc_negated[MW-1:0] : oc[MW-1:0];

        y_full = neg_reg ? (qv_reg - ONE_R) : (ONE_R - qv_reg);
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_data.action == ACT_APPLY)
                begin
                    state_next = peak_gt_trig ? ST_DIV_P : ST_FINISH;
                end
            end
            ST_DIV_P:
            begin
                if (div_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = knee_go ? ST_MUL : ST_FINISH;
            end
            ST_MUL:
            begin
                if (mcnt_reg == '0)
                begin
                    state_next = ST_DIV_Q;
                end
            end
            ST_DIV_Q:
            begin
                if (div_done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the state machine.
    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        in_acc       = in_valid && in_ready;
        out_load     = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
        div_start    = (in_acc && in_data.action == ACT_APPLY && peak_gt_trig)
                       || (state_reg == ST_MUL && mcnt_reg == '0);
        div_dividend = (state_reg == ST_MUL) ? acc_reg : (DIVW'(peak_reg) << FRAC_BITS);
        div_divisor  = (state_reg == ST_MUL) ? DW'(den_reg) : DW'(trig_div);
    end

    // Datapath next values.
    always_comb
    begin
        peak_next  = peak_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        x_next     = x_reg;
        p_next     = p_reg;
        den_next   = den_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        mcnt_next  = mcnt_reg;
        acc_next   = acc_reg;
        qneg_next  = qneg_reg;
        qv_next    = qv_reg;
        y_next     = y_reg;
        flag_next  = flag_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_data.action)
                        ACT_CLEAR:
                        begin
                            peak_next = '0;
                        end
                        ACT_MEASURE:
                        begin
                            if (mag_in > peak_reg)
                            begin
                                peak_next = mag_in;
                            end
                        end
                        ACT_APPLY:
                        begin
                            neg_next  = in_data.sample_in[SW-1];
                            mag_next  = mag_in;
                            x_next    = in_data.sample_in;
                            y_next    = in_data.sample_in;
                            flag_next = 1'b0;
                        end
                        default:
                        begin
                            peak_next = peak_reg;
                        end
                    endcase
                end
            end
            ST_DIV_P:
            begin
                if (div_done)
                begin
                    p_next = (|div_quo[DIVW-1:MAGW]) ? {MAGW{1'b1}} : div_quo[MAGW-1:0];
                end
            end
            ST_CHECK:
            begin
                den_next   = den_ext[MAGW-1:0];
                mul_a_next = DIVW'(pm_abs);
                mul_b_next = oc_abs;
                mcnt_next  = MCW'(MW);
                acc_next   = '0;
                qneg_next  = pm_neg ^ oc[MW];
                y_next     = x_reg;
                flag_next  = 1'b0;
            end
            ST_MUL:
            begin
                if (mcnt_reg != '0)
                begin
                    if (mul_b_reg[0])
                    begin
                        acc_next = acc_reg + mul_a_reg;
                    end
                    mul_a_next = mul_a_reg << 1;
                    mul_b_next = mul_b_reg >> 1;
                    mcnt_next  = mcnt_reg - 1'b1;
                end
            end
            ST_DIV_Q:
            begin
                if (div_done)
                begin
                    qv_next = qneg_reg ? -$signed(RW'(div_quo)) : $signed(RW'(div_quo));
                end
            end
            ST_SCALE:
            begin
                flag_next = 1'b1;
                if (y_full > SMAX_R)
                begin
                    y_next = SMAX_R[SW-1:0];
                end
                else if (y_full < SMIN_R)
                begin
                    y_next = SMIN_R[SW-1:0];
                end
                else
                begin
                    y_next = y_full[SW-1:0];
                end
            end
            ST_FINISH:
            begin
                y_next = y_reg;
            end
            default:
            begin
                y_next = y_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            peak_reg      <= '0;
            knee_reg      <= KNEE_RESET;
            trig_reg      <= TRIG_RESET;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            peak_reg  <= peak_next;
            mcnt_reg  <= mcnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KNEE: knee_reg <= cfg_data;
                    CFG_TRIG: trig_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        x_reg     <= x_next;
        p_reg     <= p_next;
        den_reg   <= den_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        acc_reg   <= acc_next;
        qneg_reg  <= qneg_next;
        qv_reg    <= qv_next;
        y_reg     <= y_next;
        flag_reg  <= flag_next;
        if (out_load)
        begin
            out_data_reg.sample_out     <= y_reg;
            out_data_reg.was_compressed <= flag_reg;
        end
    end

    pskc_divider #(
        .DIVW (DIVW),
        .DW   (DW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: tb/peak_soft_knee_compressor_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for peak_soft_knee_compressor_top: directed and random words
// with random idling on both sides, checked against an in-bench limiter calculation.
// Depends on pskc_pkg and the compressor RTL.
module peak_soft_knee_compressor_top_tb;
    import pskc_pkg::*;

    localparam int      FRAC_BITS    = 20;
    localparam longint  SAMPLE_MAX   = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint  SAMPLE_MIN   = -SAMPLE_MAX - 1;
    localparam longint  UNITY        = 64'sd1 <<< FRAC_BITS;
    localparam int      PAUSE_CYCLES = 150;
    localparam int      DRAIN_LIMIT  = 20000;
    localparam int      HOLD_CYCLES  = 700;
    localparam longint  CYCLE_LIMIT  = 2000000;
    localparam action_t ACT_UNUSED   = action_t'(2'd3);

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_word_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_word_t            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_WIDTH-1:0] cfg_data  = '0;

    logic [SAMPLE_WIDTH-1:0] peak_mag = '0;
    logic [REG_WIDTH-1:0]    knee_reg = KNEE_RESET;
    logic [REG_WIDTH-1:0]    trig_reg = TRIG_RESET;

    in_word_t    sample_words_q[$];
    out_word_t   limited_samples_q[$];
    int unsigned mismatch_count = 0;
    int unsigned words_taken    = 0;
    int unsigned in_gap         = 0;
    int unsigned in_quiet       = 0;
    int unsigned out_stall      = 0;
    int unsigned out_quiet      = 0;
    logic        in_fire        = 1'b0;
    logic        long_hold      = 1'b0;
    longint      cycle_count    = 0;

    peak_soft_knee_compressor_top #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic longint clip_sample(input longint v);
        if (v > SAMPLE_MAX)
        begin
            return SAMPLE_MAX;
        end
        if (v < SAMPLE_MIN)
        begin
            return SAMPLE_MIN;
        end
        return v;
    endfunction

    // Updates the stored peak and returns 1 when the word produces an output sample.
    function automatic bit apply_limiter(input in_word_t w, output out_word_t r);
        longint x;
        longint mag;
        longint y;
        longint p;
        longint knee;
        longint den;
        longint m2;
        bit     neg;
        x = $signed(w.sample_in);
        neg = (x < 0);
        mag = clip_sample(neg ? -x : x);
        y = x;
        r = '0;
        case (w.action)
            ACT_CLEAR:
            begin
                peak_mag = '0;
                return 1'b0;
            end
            ACT_MEASURE:
            begin
                if (mag > longint'(peak_mag))
                begin
                    peak_mag = mag[SAMPLE_WIDTH-1:0];
                end
                return 1'b0;
            end
            ACT_APPLY:
            begin
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        if (peak_mag > trig_reg)
        begin
            p = (longint'(peak_mag) <<< FRAC_BITS)
                / ((trig_reg == '0) ? 64'sd1 : longint'(trig_reg));
            if (p > SAMPLE_MAX)
            begin
                p = SAMPLE_MAX;
            end
            knee = longint'(knee_reg);
            den = p - knee;
            if (mag >= knee && den > 0)
            begin
                m2 = UNITY - ((p - mag) * (UNITY - knee)) / den;
                y = clip_sample(neg ? -m2 : m2);
                r.was_compressed = 1'b1;
            end
        end
        r.sample_out = y[SAMPLE_WIDTH-1:0];
        return 1'b1;
    endfunction

    function automatic int unsigned draw_gap(inout int unsigned quiet_left);
        int unsigned roll;
        if (quiet_left != 0)
        begin
            quiet_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            quiet_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 98)
        begin
            return $urandom_range(4, 16);
        end
        return $urandom_range(30, 120);
    endfunction

    function automatic int unsigned pick_level();
        case ($urandom_range(0, 5))
            0:       return 1 << 19;
            1:       return 1 << 20;
            2:       return 1100000;
            3:       return 1 << 21;
            4:       return 1 << 22;
            default: return 8388607;
        endcase
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] rand_sample(input int unsigned level);
        int mag;
        case ($urandom_range(0, 9))
            0:
            begin
                return SAMPLE_WIDTH'($urandom);
            end
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       return 24'h800000;
                    1:       return 24'h7FFFFF;
                    2:       return 24'h000000;
                    3:       return 24'hFFFFFF;
                    default: return 24'h000001;
                endcase
            end
            default:
            begin
                mag = $urandom_range(0, level);
                return $urandom_range(0, 1) ? SAMPLE_WIDTH'(-mag) : SAMPLE_WIDTH'(mag);
            end
        endcase
    endfunction

    function automatic void add_word(input action_t act, input logic [SAMPLE_WIDTH-1:0] s);
        in_word_t w;
        w.action       = act;
        w.sample_in    = s;
        sample_words_q = {sample_words_q, w};
    endfunction

    // Mostly clear / measure / apply passes with random content, the rest loose words.
    function automatic void random_burst(input int unsigned count);
        int unsigned made;
        int unsigned level;
        int unsigned k;
        action_t     act;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                level = pick_level();
                if ($urandom_range(0, 3) != 0)
                begin
                    add_word(ACT_CLEAR, rand_sample(level));
                    made++;
                end
                k = $urandom_range(1, 8);
                repeat (k) add_word(ACT_MEASURE, rand_sample(level));
                made += k;
                k = $urandom_range(1, 8);
                repeat (k) add_word(ACT_APPLY, rand_sample(level));
                made += k;
            end
            else
            begin
                act = action_t'($urandom_range(0, 3));
                add_word(act, rand_sample(pick_level()));
                if (act != ACT_UNUSED)
                begin
                    made++;
                end
            end
        end
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100)
        begin
            $display("%0t ns: mismatch: %s", $realtime, what);
        end
    endtask

    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        do @(posedge clk); while (sample_words_q.size() != 0 || in_valid);
        while (limited_samples_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (PAUSE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_WIDTH-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_KNEE)
        begin
            knee_reg = val;
        end
        else
        begin
            trig_reg = val;
        end
    endtask

    task automatic run_phase(input logic [REG_WIDTH-1:0] knee, input logic [REG_WIDTH-1:0] trig,
                             input int unsigned count);
        wait_idle();
        write_reg(CFG_KNEE, knee);
        write_reg(CFG_TRIG, trig);
        random_burst(count);
    endtask

    always @(negedge clk)
    begin : sender
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_fire)
        begin
        end
        else if (in_gap != 0)
        begin
            in_valid <= 1'b0;
            in_gap   <= in_gap - 1;
        end
        else if (sample_words_q.size() != 0)
        begin
            in_data  <= sample_words_q.pop_front();
            in_valid <= 1'b1;
            in_gap   <= draw_gap(in_quiet);
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : receiver
        if (long_hold)
        begin
            out_ready <= 1'b0;
        end
        else if (out_stall != 0)
        begin
            out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            out_stall <= draw_gap(out_quiet);
        end
    end

    // The receiver holds off long enough for the block to fill and stall its input.
    initial
    begin : receiver_hold_off
        int unsigned mark;
        mark = 250;
        repeat (2)
        begin
            do @(negedge clk); while (words_taken < mark || sample_words_q.size() < 40);
            long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            long_hold <= 1'b0;
            mark = words_taken + 300;
        end
    end

    always @(posedge clk)
    begin : monitor
        out_word_t got;
        out_word_t want;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                words_taken++;
                if (apply_limiter(in_data, got))
                begin
                    limited_samples_q = {limited_samples_q, got};
                end
            end
            if (out_valid && out_ready)
            begin
                if (limited_samples_q.size() == 0)
                begin
                    flag_mismatch($sformatf("output word %h with none pending", out_data));
                end
                else
                begin
                    want = limited_samples_q.pop_front();
                    if (out_data.sample_out !== want.sample_out)
                    begin
                        flag_mismatch($sformatf("sample_out %h, want %h",
                                                out_data.sample_out, want.sample_out));
                    end
                    if (out_data.was_compressed !== want.was_compressed)
                    begin
                        flag_mismatch($sformatf("was_compressed %b, want %b",
                                                out_data.was_compressed, want.was_compressed));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_word(ACT_CLEAR, 24'h000000);
        add_word(ACT_APPLY, 24'h7FFFFF);
        add_word(ACT_MEASURE, 24'h800000);
        add_word(ACT_APPLY, 24'h7FFFFF);
        add_word(ACT_APPLY, 24'h800000);
        add_word(ACT_APPLY, 24'h000000);
        add_word(ACT_APPLY, 24'd525533);
        add_word(ACT_APPLY, 24'd525532);
        add_word(ACT_APPLY, -24'sd525533);
        add_word(ACT_APPLY, 24'hFFFFFF);
        add_word(ACT_UNUSED, 24'hFFFFFF);
        add_word(ACT_APPLY, 24'h555555);
        add_word(ACT_CLEAR, 24'hFFFFFF);
        add_word(ACT_MEASURE, 24'd1038090);
        add_word(ACT_APPLY, 24'd1048575);
        add_word(ACT_MEASURE, -24'sd1038091);
        add_word(ACT_APPLY, 24'd1048576);
        add_word(ACT_APPLY, -24'sd700000);
        add_word(ACT_UNUSED, 24'h000000);
        add_word(ACT_APPLY, 24'h2AAAAA);
        add_word(ACT_CLEAR, 24'h000000);
        add_word(ACT_APPLY, 24'd123);
        random_burst(90);

        run_phase(21'd0, 21'd1, 120);
        run_phase(21'd1048576, 21'd1048576, 120);
        run_phase(21'd2097151, 21'd1048576, 110);
        run_phase(REG_WIDTH'($urandom_range(0, 1048576)), 21'd0, 110);
        run_phase(21'd262144, 21'd524288, 120);
        run_phase(REG_WIDTH'($urandom_range(0, 1048576)),
                  REG_WIDTH'($urandom_range(1, 1048576)), 130);
        run_phase(21'd1048576, 21'd1, 120);
        run_phase(21'd0, 21'd1048576, 130);

        wait_idle();
        if (limited_samples_q.size() != 0)
        begin
            flag_mismatch($sformatf("%0d output words never arrived", limited_samples_q.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
